// ===== rtl/core/fifo_with_indexed_peek_macros.svh =====
// ---------------------------------------------------------------------------
// fifo_with_indexed_peek_macros
// Assertion macros for the queue RTL.
// ---------------------------------------------------------------------------
`ifndef FIFO_WITH_INDEXED_PEEK_MACROS_SVH
`define FIFO_WITH_INDEXED_PEEK_MACROS_SVH

`ifndef SYNTH
`define FWIP_ASSERT_NOW(label, clk, rstn, ante, cons) \
    label: assert property (@(posedge clk) disable iff (!rstn) (ante) |-> (cons)) \
        else $error("fwip: assertion failed");
`define FWIP_ASSERT_NEXT(label, clk, rstn, ante, cons) \
    label: assert property (@(posedge clk) disable iff (!rstn) (ante) |=> (cons)) \
        else $error("fwip: assertion failed");
`else
`define FWIP_ASSERT_NOW(label, clk, rstn, ante, cons)
`define FWIP_ASSERT_NEXT(label, clk, rstn, ante, cons)
`endif

`endif

// ===== rtl/core/fwip_pkg.sv =====
// ---------------------------------------------------------------------------
// fwip_pkg
// Operation codes, status codes and shared types of the indexed-peek queue.
// ---------------------------------------------------------------------------
package fwip_pkg;

    typedef logic [1:0] func_t;
    typedef logic [1:0] status_t;

    localparam func_t FN_PUSH = 2'd0;
    localparam func_t FN_POP  = 2'd1;
    localparam func_t FN_PEEK = 2'd2;

    localparam status_t ST_OK    = 2'd0;
    localparam status_t ST_EMPTY = 2'd1;
    localparam status_t ST_FULL  = 2'd2;
    localparam status_t ST_RANGE = 2'd3;

    typedef struct packed {
        logic wr_en;
        logic rd_en;
    } mem_cmd_t;

endpackage

// ===== rtl/core/fifo_with_indexed_peek.sv =====
// ---------------------------------------------------------------------------
// fifo_with_indexed_peek
// Bounded queue of signed words with push, pop and indexed peek with drop.
// ---------------------------------------------------------------------------
//  channel   handshake        payload
//  request   start / busy     func, push_value, position, from_rear, drop_before
//  result    done (strobe)    value, status, occupancy
//
//  One request per cycle; busy stays low.
//  The result strobes in the cycle after the request is taken.
//  The single port of the entry store serves the one access each request needs.
//  Reset clears head pointer and fill count at once; the store needs no pass.
//  Results are not held: the receiver takes each one in its strobe cycle.
module fifo_with_indexed_peek
    import fwip_pkg::*;
#(
    parameter int DEPTH = 64
)
(
    input  logic                            clk,
    input  logic                            rst_n,
    input  logic                            start,
    output logic                            busy,
    input  func_t                           func,
    input  logic signed [31:0]              push_value,
    input  logic [$clog2(DEPTH + 1)-1:0]    position,
    input  logic                            from_rear,
    input  logic                            drop_before,
    output logic                            done,
    output logic signed [31:0]              value,
    output status_t                         status,
    output logic [$clog2(DEPTH + 1)-1:0]    occupancy
);

    localparam int AW = $clog2(DEPTH);
    localparam int CW = $clog2(DEPTH + 1);

    mem_cmd_t           cmd;
    logic [AW-1:0]      addr;
    logic signed [31:0] rdata;
    logic               val_sel;

    assign busy = 1'b0;

    fwip_ctrl #(
        .DEPTH (DEPTH),
        .AW    (AW),
        .CW    (CW)
    ) u_ctrl (
        .clk         (clk),
        .rst_n       (rst_n),
        .start       (start),
        .func        (func),
        .position    (position),
        .from_rear   (from_rear),
        .drop_before (drop_before),
        .cmd         (cmd),
        .addr        (addr),
        .done        (done),
        .val_sel     (val_sel),
        .status      (status),
        .occupancy   (occupancy)
    );

    fwip_mem #(
        .DEPTH (DEPTH),
        .AW    (AW)
    ) u_mem (
        .clk   (clk),
        .cmd   (cmd),
        .addr  (addr),
        .wdata (push_value),
        .rdata (rdata)
    );

    assign value = val_sel ? rdata : 32'sd0;

endmodule

// ===== rtl/core/fwip_mem.sv =====
// ---------------------------------------------------------------------------
// fwip_mem
// Entry store: one port, synchronous write or registered read.
// ---------------------------------------------------------------------------
module fwip_mem
    import fwip_pkg::*;
#(
    parameter int DEPTH = 64,
    parameter int AW    = $clog2(DEPTH)
)
(
    input  logic                clk,
    input  mem_cmd_t            cmd,
    input  logic [AW-1:0]       addr,
    input  logic signed [31:0]  wdata,
    output logic signed [31:0]  rdata
);

    logic signed [31:0] store [DEPTH];
    logic signed [31:0] rdata_reg;

    always_ff @(posedge clk)
    begin
        if (cmd.wr_en)
        begin
            store[addr] <= wdata;
        end
    end

    always_ff @(posedge clk)
    begin
        if (cmd.rd_en)
        begin
            rdata_reg <= store[addr];
        end
    end

    assign rdata = rdata_reg;

endmodule

// ===== rtl/core/fwip_ctrl.sv =====
// ---------------------------------------------------------------------------
// fwip_ctrl
// Request decode, head pointer, fill count and result registers.
// ---------------------------------------------------------------------------
`include "fifo_with_indexed_peek_macros.svh"

module fwip_ctrl
    import fwip_pkg::*;
#(
    parameter int DEPTH = 64,
    parameter int AW    = $clog2(DEPTH),
    parameter int CW    = $clog2(DEPTH + 1)
)
(
    input  logic            clk,
    input  logic            rst_n,
    input  logic            start,
    input  func_t           func,
    input  logic [CW-1:0]   position,
    input  logic            from_rear,
    input  logic            drop_before,
    output mem_cmd_t        cmd,
    output logic [AW-1:0]   addr,
    output logic            done,
    output logic            val_sel,
    output status_t         status,
    output logic [CW-1:0]   occupancy
);

    localparam logic [CW-1:0] FULL_CNT = CW'(DEPTH);
    localparam logic [AW:0]   WRAP     = (AW + 1)'(DEPTH);

    function automatic logic [AW-1:0] wrap_add(input logic [AW-1:0] base,
                                               input logic [CW-1:0] off);
        logic [AW:0] sum;
        begin
            sum = {1'b0, base} + {1'b0, off[AW-1:0]};
            if (sum >= WRAP)
            begin
                sum = sum - WRAP;
            end
            return sum[AW-1:0];
        end
    endfunction

    logic [AW-1:0] head_reg, head_next;
    logic [CW-1:0] count_reg, count_next;
    logic          done_reg, done_next;
    logic          sel_reg, sel_next;
    status_t       status_reg, status_next;
    logic [CW-1:0] occ_reg;

    logic [CW-1:0] ahead;
    logic [AW-1:0] tail_slot;
    logic [AW-1:0] peek_slot;
    logic [AW-1:0] head_inc;
    logic          range_bad;

    assign ahead     = from_rear ? (count_reg - position) : (position - CW'(1));
    assign tail_slot = wrap_add(head_reg, count_reg);
    assign peek_slot = wrap_add(head_reg, ahead);
    assign head_inc  = (head_reg == AW'(DEPTH - 1)) ? '0 : head_reg + AW'(1);
    assign range_bad = (position == '0) || (position > count_reg);

    always_comb
    begin
        head_next   = head_reg;
        count_next  = count_reg;
        status_next = ST_OK;
        sel_next    = 1'b0;
        done_next   = start;
        cmd         = '0;
        addr        = head_reg;
        if (start)
        begin
            unique case (func)
                FN_PUSH:
                begin
                    addr = tail_slot;
                    if (count_reg == FULL_CNT)
                    begin
                        status_next = ST_FULL;
                    end
                    else
                    begin
                        cmd.wr_en  = 1'b1;
                        count_next = count_reg + CW'(1);
                    end
                end
                FN_POP:
                begin
                    if (count_reg == '0)
                    begin
                        status_next = ST_EMPTY;
                    end
                    else
                    begin
                        cmd.rd_en  = 1'b1;
                        sel_next   = 1'b1;
                        head_next  = head_inc;
                        count_next = count_reg - CW'(1);
                    end
                end
                FN_PEEK:
                begin
                    addr = peek_slot;
                    if (count_reg == '0)
                    begin
                        status_next = ST_EMPTY;
                    end
                    else if (range_bad)
                    begin
                        status_next = ST_RANGE;
                    end
                    else
                    begin
                        cmd.rd_en = 1'b1;
                        sel_next  = 1'b1;
                        if (drop_before)
                        begin
                            head_next  = peek_slot;
                            count_next = count_reg - ahead;
                        end
                    end
                end
                default:
                begin
                end
            endcase
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            head_reg   <= '0;
            count_reg  <= '0;
            done_reg   <= 1'b0;
            sel_reg    <= 1'b0;
            status_reg <= ST_OK;
            occ_reg    <= '0;
        end
        else
        begin
            head_reg   <= head_next;
            count_reg  <= count_next;
            done_reg   <= done_next;
            sel_reg    <= sel_next;
            status_reg <= status_next;
            occ_reg    <= count_next;
        end
    end

    assign done      = done_reg;
    assign val_sel   = sel_reg;
    assign status    = status_reg;
    assign occupancy = occ_reg;

    `FWIP_ASSERT_NOW(a_count_bound, clk, rst_n, 1'b1, count_reg <= FULL_CNT)
    `FWIP_ASSERT_NOW(a_occ_tracks, clk, rst_n, done_reg, occ_reg == count_reg)
    `FWIP_ASSERT_NOW(a_full_occ, clk, rst_n, done_reg && (status_reg == ST_FULL), occ_reg == FULL_CNT)
    `FWIP_ASSERT_NOW(a_sel_ok, clk, rst_n, sel_reg, done_reg && (status_reg == ST_OK))
    `FWIP_ASSERT_NEXT(a_pop_dec, clk, rst_n, start && (func == FN_POP) && (count_reg != '0), count_reg == $past(count_reg) - CW'(1))

endmodule
